// ===== hw/rtl/cabinet_impulse_convolver_assert.svh =====
// Assertion macros for the cabinet impulse convolver checkers.
// Expects signals named clk and rst_n (active low) in the using scope.
`ifndef CABINET_IMPULSE_CONVOLVER_ASSERT_SVH
`define CABINET_IMPULSE_CONVOLVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cic_pkg.sv =====
// Shared types and constants for the cabinet impulse convolver.
// No dependencies; imported by every module of the block except cic_ram.
package cic_pkg;

    // Fixed field widths of the stream and configuration port
    localparam int TAP_COUNT_W = 11;
    localparam int INDEX_W     = 10;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 11'd897;

    // Item kinds carried in tuser
    localparam logic CMD_AUDIO = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    // Tags that travel with each tap read through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

// ===== hw/rtl/cic_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cic_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cic_seq.sv =====
// Sequencer: clearing pass, input transactions, RAM writes and tap read issue.
// Depends on cic_pkg.
module cic_seq
    import cic_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 24,
    localparam int AW = $clog2(MAX_TAPS),
    localparam int TW = $clog2(MAX_TAPS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TAP_COUNT_W-1:0] tap_count,
    // input transactions
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_cmd,
    input  logic [INDEX_W-1:0]     in_index,
    input  logic [SAMPLE_BITS-1:0] in_coeff,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    // coefficient RAM
    output logic                   coeff_we,
    output logic [AW-1:0]          coeff_waddr,
    output logic [SAMPLE_BITS-1:0] coeff_wdata,
    output logic [AW-1:0]          coeff_raddr,
    // history RAM
    output logic                   hist_we,
    output logic [AW-1:0]          hist_waddr,
    output logic [SAMPLE_BITS-1:0] hist_wdata,
    output logic [AW-1:0]          hist_raddr,
    output logic                   rd_en,
    // MAC pipeline
    output mac_ctrl_t              mac_ctrl,
    input  logic                   retire
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_TAPS - 1);

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] ptr_reg,   ptr_next;
    logic [AW-1:0] slot_reg,  slot_next;
    logic [AW-1:0] k_reg,     k_next;     // tap index; also the clearing address
    logic [TW-1:0] taps_reg,  taps_next;

    logic          clearing;
    logic          accept;
    logic          last_tap;
    logic [31:0]   idx_wide;
    logic [31:0]   tc_wide;
    logic [TW-1:0] taps_clamped;

    assign clearing = (state_reg == ST_CLEAR);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign idx_wide = 32'(in_index);
    assign tc_wide  = 32'(tap_count);
    assign last_tap = (TW'(k_reg) == (taps_reg - TW'(1)));

    // Tap count zero counts as one, above the store depth as the full depth
    always_comb
    begin
        if (tc_wide == 32'd0)
        begin
            taps_clamped = TW'(1);
        end
        else if (tc_wide > 32'(MAX_TAPS))
        begin
            taps_clamped = TW'(MAX_TAPS);
        end
        else
        begin
            taps_clamped = TW'(tc_wide);
        end
    end

    // RAM writes: zero fill while clearing, else loads and audio samples
    assign coeff_we    = clearing ||
                         (accept && (in_cmd == CMD_LOAD) && (idx_wide < 32'(MAX_TAPS)));
    assign coeff_waddr = clearing ? k_reg : idx_wide[AW-1:0];
    assign coeff_wdata = clearing ? '0 : in_coeff;
    assign hist_we     = clearing || (accept && (in_cmd == CMD_AUDIO));
    assign hist_waddr  = clearing ? k_reg : ptr_reg;
    assign hist_wdata  = clearing ? '0 : in_sample;

    // Tap reads: coefficient k against the sample k steps back
    assign rd_en          = (state_reg == ST_RUN);
    assign coeff_raddr    = k_reg;
    assign hist_raddr     = slot_reg;
    assign mac_ctrl.valid = rd_en;
    assign mac_ctrl.first = (k_reg == '0);
    assign mac_ctrl.last  = last_tap;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        slot_next  = slot_reg;
        k_next     = k_reg;
        taps_next  = taps_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                k_next = k_reg + AW'(1);
                if (k_reg == ADDR_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_AUDIO))
                begin
                    slot_next  = ptr_reg;
                    k_next     = '0;
                    taps_next  = taps_clamped;
                    ptr_next   = (ptr_reg == ADDR_LAST) ? '0 : ptr_reg + AW'(1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                k_next    = k_reg + AW'(1);
                slot_next = (slot_reg == '0) ? ADDR_LAST : slot_reg - AW'(1);
                if (last_tap)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            slot_reg  <= '0;
            k_reg     <= '0;
            taps_reg  <= TW'(1);
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            slot_reg  <= slot_next;
            k_reg     <= k_next;
            taps_reg  <= taps_next;
        end
    end

endmodule

// ===== hw/rtl/cic_mac.sv =====
// MAC datapath: multiply, wide accumulate, round, saturate, output register.
// Depends on cic_pkg.
module cic_mac
    import cic_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mac_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] coeff_rdata,
    input  logic [SAMPLE_BITS-1:0] hist_rdata,
    output logic                   retire,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_data
);

    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int ACC_W = PW + $clog2(MAX_TAPS);

    localparam logic [ACC_W-1:0]       RND_HALF = ACC_W'(1) << (SAMPLE_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    mac_ctrl_t               s1_ctrl_reg;
    mac_ctrl_t               s2_ctrl_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W-1:0]        acc_reg;
    logic                    done_reg;
    logic                    rnd_valid_reg;
    logic [ACC_W-1:0]        rnd_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_data_reg;
    logic [ACC_W-PW+1:0]     rnd_hi;
    logic                    in_range;
    logic [SAMPLE_BITS-1:0]  sat_value;

    // Tags follow the RAM read latency and the multiplier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg <= ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
            done_reg    <= s2_ctrl_reg.valid && s2_ctrl_reg.last;
        end
    end

    // Product of coefficient and delayed sample
    always_ff @(posedge clk)
    begin
        if (s1_ctrl_reg.valid)
        begin
            prod_reg <= $signed(coeff_rdata) * $signed(hist_rdata);
        end
    end

    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};

    // Accumulate; the first tap reloads
    always_ff @(posedge clk)
    begin
        if (s2_ctrl_reg.valid)
        begin
            acc_reg <= s2_ctrl_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    // Round half up at the sample LSB
    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            rnd_reg <= acc_reg + RND_HALF;
        end
    end

    // Saturate: in range when every bit from 2*SB-2 up is a sign copy
    assign rnd_hi    = rnd_reg[ACC_W-1:PW-2];
    assign in_range  = (&rnd_hi) || !(|rnd_hi);
    assign sat_value = in_range ? rnd_reg[PW-2:SAMPLE_BITS-1]
                                : (rnd_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // Rounded result moves on once the output register is free
    assign retire = rnd_valid_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (done_reg)
            begin
                rnd_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                rnd_valid_reg <= 1'b0;
            end

            if (retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_data_reg <= sat_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/cabinet_impulse_convolver.sv =====
// Top level of the cabinet impulse convolver (direct-form FIR over a loaded IR).
// Depends on cic_pkg, cic_ram, cic_seq and cic_mac.
//
//  port group   dir  handshake          payload
//  s_*          in   s_tvalid/s_tready  tuser = cmd, tdata = index, coeff, sample
//  m_*          out  m_tvalid/m_tready  tdata = sample_out
//  cfg_*        in   cfg_wr_en          cfg_wr_data = tap_count
//
//  Audio transaction: one MAC per tap, set by the single read port of each
//  RAM; the next input is taken only once the result has moved into the
//  output register. Load transaction: written as it is accepted.
//  After reset both RAMs are zeroed, one entry per cycle; s_tready stays low
//  meanwhile. A result held by a stalled m_tready does not block the next
//  input; the one after it waits for the output register.
module cabinet_impulse_convolver
    import cic_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 24,
    localparam int IN_TDATA_W  = ((INDEX_W + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [TAP_COUNT_W-1:0] cfg_wr_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // coeff_index, coeff_value, sample_in, zero pad
    input  logic [0:0]             s_tuser,   // cmd
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // sample_out, zero pad
);

    localparam int AW = $clog2(MAX_TAPS);

    logic [TAP_COUNT_W-1:0] tap_count_reg;

    logic [INDEX_W-1:0]     coeff_index;
    logic [SAMPLE_BITS-1:0] coeff_value;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS-1:0] sample_out;

    logic                   coeff_we;
    logic [AW-1:0]          coeff_waddr;
    logic [SAMPLE_BITS-1:0] coeff_wdata;
    logic [AW-1:0]          coeff_raddr;
    logic [SAMPLE_BITS-1:0] coeff_rdata;
    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic [SAMPLE_BITS-1:0] hist_wdata;
    logic [AW-1:0]          hist_raddr;
    logic [SAMPLE_BITS-1:0] hist_rdata;
    logic                   rd_en;
    mac_ctrl_t              mac_ctrl;
    logic                   retire;

    // Tap count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            tap_count_reg <= cfg_wr_data;
        end
    end

    // Unpack the input payload
    assign coeff_index = s_tdata[INDEX_W-1:0];
    assign coeff_value = s_tdata[INDEX_W+SAMPLE_BITS-1:INDEX_W];
    assign sample_in   = s_tdata[INDEX_W+2*SAMPLE_BITS-1:INDEX_W+SAMPLE_BITS];
    assign m_tdata     = OUT_TDATA_W'(sample_out);

    cic_seq #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .tap_count   (tap_count_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser[0]),
        .in_index    (coeff_index),
        .in_coeff    (coeff_value),
        .in_sample   (sample_in),
        .coeff_we    (coeff_we),
        .coeff_waddr (coeff_waddr),
        .coeff_wdata (coeff_wdata),
        .coeff_raddr (coeff_raddr),
        .hist_we     (hist_we),
        .hist_waddr  (hist_waddr),
        .hist_wdata  (hist_wdata),
        .hist_raddr  (hist_raddr),
        .rd_en       (rd_en),
        .mac_ctrl    (mac_ctrl),
        .retire      (retire)
    );

    // Coefficient store
    cic_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (coeff_waddr),
        .wdata (coeff_wdata),
        .re    (rd_en),
        .raddr (coeff_raddr),
        .rdata (coeff_rdata)
    );

    // Sample history, circular
    cic_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (rd_en),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    cic_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .coeff_rdata (coeff_rdata),
        .hist_rdata  (hist_rdata),
        .retire      (retire),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (sample_out)
    );

endmodule

// ===== hw/rtl/cic_checker.sv =====
// Port-level checker for the cabinet impulse convolver, bound to the top level.
// Depends on cic_pkg and cabinet_impulse_convolver_assert.svh.
`include "cabinet_impulse_convolver_assert.svh"

module cic_checker
    import cic_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 24,
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [0:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic audio_taken;
    logic results_possible;

    assign audio_taken      = s_tvalid && s_tready && (s_tuser[0] == CMD_AUDIO);
    assign results_possible = (MAX_TAPS > 0);

    // A stalled result holds
    `CIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // An audio transaction occupies the block: no input the next cycle
    `CIC_ASSERT_NEXT(a_audio_busy, audio_taken, !s_tready, "input taken while filter busy")

    // An idle block with no input stays ready
    `CIC_ASSERT_NEXT(a_idle_stays, s_tready && !s_tvalid && results_possible, s_tready, "ready dropped with no input")

    // A new result only appears while a filter run was in progress
    `CIC_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(!s_tready), "result without a run")

endmodule

bind cabinet_impulse_convolver cic_checker #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_cabinet_impulse_convolver.sv =====
`timescale 1ns / 1ps
// Testbench for cabinet_impulse_convolver: a directed stimulus table, then random
// coefficient loads and audio transactions checked against a behavioural FIR model.
// Depends on cic_pkg and the cabinet_impulse_convolver RTL.
module tb_cabinet_impulse_convolver;
    import cic_pkg::*;

    localparam int MAX_TAPS       = 1024;
    localparam int SAMPLE_BITS    = 24;
    localparam int IN_W           = ((INDEX_W + 2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W          = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PAD_W          = IN_W - INDEX_W - 2 * SAMPLE_BITS;
    // clearing pass + full-length convolution + longest gaps, taken several times over
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_HOLD       = MAX_TAPS + 64;

    // Directed table row kinds
    typedef enum logic [1:0] {ROW_LOAD, ROW_AUDIO, ROW_TAPS} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [10:0] arg;     // coefficient index or tap count
        logic [23:0] value;   // coefficient or dry sample
        logic        typed;   // expected output given in the row
        logic [23:0] want;
    } stim_row_t;

    localparam int N_ROWS = 25;
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_AUDIO, 11'd0,    24'h123456, 1'b1, 24'h000000},  // zero IR after reset
        '{ROW_LOAD,  11'd0,    24'h800000, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h800000, 1'b1, 24'h7FFFFF},  // overflow, positive
        '{ROW_AUDIO, 11'd0,    24'h7FFFFF, 1'b1, 24'h800001},
        '{ROW_LOAD,  11'd1023, 24'h7FFFFF, 1'b0, 24'h000000},
        '{ROW_LOAD,  11'd1,    24'h7FFFFF, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h000000, 1'b0, 24'h000000},
        '{ROW_TAPS,  11'd0,    24'h000000, 1'b0, 24'h000000},  // zero taps acts as one
        '{ROW_AUDIO, 11'd0,    24'h7FFFFF, 1'b1, 24'h800001},
        '{ROW_TAPS,  11'd1024, 24'h000000, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_TAPS,  11'd2047, 24'h000000, 1'b0, 24'h000000},  // clamped to full length
        '{ROW_AUDIO, 11'd0,    24'h2AAAAA, 1'b0, 24'h000000},
        '{ROW_LOAD,  11'd1023, 24'h555555, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'hD55555, 1'b0, 24'h000000},
        '{ROW_TAPS,  11'd2,    24'h000000, 1'b0, 24'h000000},
        '{ROW_LOAD,  11'd1,    24'h800000, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h7FFFFF, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h7FFFFF, 1'b1, 24'h800000},  // overflow, negative
        '{ROW_TAPS,  11'd1,    24'h000000, 1'b0, 24'h000000},
        '{ROW_LOAD,  11'd0,    24'h400000, 1'b0, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h000001, 1'b1, 24'h000001},  // half rounds up
        '{ROW_AUDIO, 11'd0,    24'hFFFFFF, 1'b1, 24'h000000},
        '{ROW_AUDIO, 11'd0,    24'h000003, 1'b1, 24'h000002},
        '{ROW_LOAD,  11'd512,  24'h000001, 1'b0, 24'h000000}
    };

    // Random phases: tap count and number of transactions
    localparam int N_PHASES = 11;
    int phase_taps  [N_PHASES] = '{5, 16, 1, 1024, 33, 0, 2047, 8, 897, 64, 2};
    int phase_items [N_PHASES] = '{70, 60, 50, 20, 60, 40, 16, 60, 14, 60, 60};

    // DUT connections
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [TAP_COUNT_W-1:0] cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata     = '0;   // coeff_index, coeff_value, sample_in, zero pad
    logic [0:0]             s_tuser     = CMD_AUDIO;  // cmd
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_W-1:0]       m_tdata;            // sample_out

    // FIR model state
    logic signed [23:0]     ir_coeffs   [MAX_TAPS];
    logic signed [23:0]     dry_history [MAX_TAPS];
    int unsigned            history_slot = 0;
    logic [TAP_COUNT_W-1:0] taps_setting = TAP_COUNT_RESET;
    logic [23:0]            expected_out [$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit steady      = 1'b0;
    bit bus_held    = 1'b0;

    cabinet_impulse_convolver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Direct-form FIR on one new dry sample, rounded half up and saturated
    function automatic logic [23:0] convolve_sample(logic signed [23:0] dry);
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        int n;
        int k;
        int slot;
        dry_history[history_slot] = dry;
        n = int'(taps_setting);
        if (n < 1)
            n = 1;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        acc = '0;
        for (k = 0; k < n; k++)
        begin
            slot = (int'(history_slot) + MAX_TAPS - k) % MAX_TAPS;
            acc  = acc + ir_coeffs[k] * dry_history[slot];
        end
        history_slot = (history_slot + 1) % MAX_TAPS;
        scaled = (acc + 64'sd4194304) >>> (SAMPLE_BITS - 1);
        if (scaled > 64'sd8388607)
            return 24'h7FFFFF;
        if (scaled < -64'sd8388608)
            return 24'h800000;
        return scaled[23:0];
    endfunction

    // Sender gap: mostly none, a few short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [23:0] pick_coeff();
        logic signed [18:0] modest;
        int r;
        r = $urandom_range(0, 9);
        modest = 19'($urandom);
        case (r)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return ($urandom_range(0, 1) != 0) ? 24'h000000 : 24'hFFFFFF;
            3, 4, 5: return 24'(modest);   // keeps long sums out of saturation
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    // One input transaction; the bus is left valid so back-to-back items need no gap
    task automatic apply_item(input logic cmd, input logic [9:0] idx,
                              input logic [23:0] coeff, input logic [23:0] dry,
                              input bit typed, input logic [23:0] want);
        int g;
        logic [23:0] got;
        g = steady ? 0 : pick_gap();
        if (g > 0)
        begin
            if (bus_held)
                s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, dry, coeff, idx};
        bus_held  = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == CMD_LOAD)
            ir_coeffs[idx] = coeff;
        else
        begin
            got = convolve_sample(dry);
            expected_out.push_back(typed ? want : got);
        end
    endtask

    // Drop valid and wait until every expected sample has come out
    task automatic await_output_drained();
        if (bus_held)
            s_tvalid <= 1'b0;
        bus_held = 1'b0;
        do
            @(posedge clk);
        while (expected_out.size() != 0);
    endtask

    task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] taps);
        await_output_drained();
        // a load may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= taps;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        taps_setting  = taps;
    endtask

    // Output checker and receiver back-pressure
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("sample_out: unexpected transaction, expected none, actual %0d",
                       $signed(m_tdata[23:0]));
                fail_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata[23:0] !== want)
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(want), $signed(m_tdata[23:0]));
                    fail_count++;
                end
            end
        end
        if (steady)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = pick_stall() - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t row;
        int  ph;
        int  n;
        int  eff;
        logic [9:0] idx;
        for (n = 0; n < MAX_TAPS; n++)
        begin
            ir_coeffs[n]   = '0;
            dry_history[n] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (n = 0; n < N_ROWS; n++)
        begin
            row = directed_rows[n];
            case (row.kind)
                ROW_LOAD:
                    apply_item(CMD_LOAD, row.arg[9:0], row.value, pick_sample(), 1'b0, '0);
                ROW_AUDIO:
                    apply_item(CMD_AUDIO, 10'($urandom), 24'($urandom), row.value,
                               row.typed, row.want);
                default:
                    set_tap_count(row.arg);
            endcase
        end

        // random phases, one tap count each
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            set_tap_count(TAP_COUNT_W'(phase_taps[ph]));
            steady = (ph % 3 == 1);
            eff = phase_taps[ph];
            if (eff < 1)
                eff = 1;
            if (eff > MAX_TAPS)
                eff = MAX_TAPS;
            for (n = 0; n < phase_items[ph]; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    await_output_drained();
                if ($urandom_range(0, 99) < 45)
                begin
                    // loads mostly land on taps in use
                    if ($urandom_range(0, 3) == 0)
                        idx = 10'($urandom);
                    else
                        idx = 10'($urandom_range(0, (eff < MAX_TAPS) ? eff : MAX_TAPS - 1));
                    apply_item(CMD_LOAD, idx, pick_coeff(), 24'($urandom), 1'b0, '0);
                end
                else
                    apply_item(CMD_AUDIO, 10'($urandom), 24'($urandom), pick_sample(),
                               1'b0, '0);
            end
        end

        steady = 1'b0;
        await_output_drained();
        repeat (END_HOLD) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
